### hdl/fvn_pkg.sv
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants and bus types for the fractal value noise pipeline.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int unsigned MAX_OCTAVES_DEF = 8;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned NOISE_W = 18;
    localparam int unsigned FREQ_W  = 32;
    localparam int unsigned AMP_W   = 32;
    localparam int unsigned TOTAL_W = 64;
    // Holds the sum of up to sixteen full-scale amplitudes.
    localparam int unsigned NORM_W  = 37;
    localparam int unsigned DEN_W   = NORM_W + 8;
    localparam int unsigned QUO_W   = 18;

    localparam logic [31:0] HASH_MUL_X  = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y  = 32'd668265263;
    localparam logic [31:0] HASH_MUL_M  = 32'd1274126177;
    localparam logic [31:0] HASH_MASK   = 32'h00ffffff;
    localparam logic [31:0] SEED_STEP   = 32'd101;

    localparam logic [FREQ_W-1:0] FREQ_ONE = 32'd4096;
    localparam logic [AMP_W-1:0]  AMP_ONE  = 32'd16384;
    localparam logic [17:0] NOISE_FULL     = 18'd65536;

    localparam logic [31:0] SEED_RST = 32'd0;
    localparam logic [3:0]  OCT_RST  = 4'd4;
    localparam logic [15:0] LAC_RST  = 16'd8192;
    localparam logic [15:0] GAIN_RST = 16'd8192;

    typedef enum logic [2:0] {
        REG_SEED    = 3'd0,
        REG_OCTAVES = 3'd1,
        REG_LACUN   = 3'd2,
        REG_GAIN    = 3'd3
    } reg_idx_t;

    // Data handed from one octave stage to the next.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FREQ_W-1:0]  freq;
        logic [AMP_W-1:0]   amp;
        logic [TOTAL_W-1:0] total;
        logic [NORM_W-1:0]  norm;
    } oct_bus_t;

    // Data handed from one divider step to the next.
    typedef struct packed {
        logic [63:0]      rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             zero;
        logic             ovf;
    } div_bus_t;

endpackage

### hdl/fvn_octave_cell.sv
// ----------------------------------------------------------------------------
// fvn_octave_cell
// One octave of value noise: scale, hash four corners, blend, accumulate.
// ----------------------------------------------------------------------------
module fvn_octave_cell #(
    parameter int unsigned K = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 active,
    input  logic [31:0]          noise_seed,
    input  logic [15:0]          lacunarity,
    input  logic [15:0]          gain,
    input  logic                 in_valid,
    input  fvn_pkg::oct_bus_t    in_bus,
    output logic                 out_valid,
    output fvn_pkg::oct_bus_t    out_bus
);

    localparam logic [31:0] SEED_OFS = 32'(K * 101);

    function automatic logic [23:0] blend24(input logic [23:0] a, input logic [23:0] b,
                                            input logic [16:0] s);
        logic [40:0] pa;
        logic [40:0] pb;
        logic [40:0] sum;
        begin
            pa  = {17'd0, a} * {24'd0, 17'd65536 - s};
            pb  = {17'd0, b} * {24'd0, s};
            sum = pa + pb;
            blend24 = sum[39:16];
        end
    endfunction

    function automatic logic [31:0] corner_mix(input logic [31:0] seed, input logic [31:0] hx,
                                               input logic [31:0] hy);
        logic [31:0] h;
        begin
            h = seed ^ hx ^ hy;
            corner_mix = (h ^ (h >> 13)) * fvn_pkg::HASH_MUL_M;
        end
    endfunction

    function automatic logic [23:0] corner_fin(input logic [31:0] m);
        logic [31:0] h;
        begin
            h = (m ^ (m >> 16)) & fvn_pkg::HASH_MASK;
            corner_fin = h[23:0];
        end
    endfunction

    logic [31:0] seed;
    assign seed = noise_seed + SEED_OFS;

    // pass-through line for the bus, current amplitude and active flag
    fvn_pkg::oct_bus_t pass_reg [1:6];
    logic [31:0]       amp_reg  [1:6];
    logic              act_reg  [1:6];
    logic              vld_reg  [1:6];

    // stage 1: coordinate scaling, next frequency and amplitude
    logic signed [64:0] px_full;
    logic signed [64:0] py_full;
    logic [47:0]        fmul;
    logic [47:0]        amul;
    logic [31:0]        nfreq;
    logic [31:0]        namp;
    logic [47:0]        px_reg;
    logic [47:0]        py_reg;
    fvn_pkg::oct_bus_t  pass1_next;

    assign px_full = $signed(in_bus.x) * $signed({1'b0, in_bus.freq});
    assign py_full = $signed(in_bus.y) * $signed({1'b0, in_bus.freq});
    assign fmul    = {16'd0, in_bus.freq} * {32'd0, lacunarity};
    assign amul    = {16'd0, in_bus.amp} * {32'd0, gain};
    assign nfreq   = (|fmul[47:44]) ? 32'hffffffff : fmul[43:12];
    assign namp    = (|amul[47:46]) ? 32'hffffffff : amul[45:14];

    always_comb
    begin
        pass1_next      = in_bus;
        pass1_next.freq = nfreq;
        pass1_next.amp  = namp;
    end

    // stage 1 registers and the pass line through stages 2..6
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg      <= px_full[59:12];
            py_reg      <= py_full[59:12];
            pass_reg[1] <= pass1_next;
            amp_reg[1]  <= in_bus.amp;
            act_reg[1]  <= active;
            for (int i = 2; i <= 6; i++)
            begin
                pass_reg[i] <= pass_reg[i-1];
                amp_reg[i]  <= amp_reg[i-1];
                act_reg[i]  <= act_reg[i-1];
            end
        end
    end

    // stage 2: corner products for the hash, fraction squares
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [31:0] hx0_reg;
    logic [31:0] hx1_reg;
    logic [31:0] hy0_reg;
    logic [31:0] hy1_reg;
    logic [31:0] ttx_reg;
    logic [31:0] tty_reg;
    logic [15:0] tx_reg;
    logic [15:0] ty_reg;

    assign x0 = px_reg[47:16];
    assign y0 = py_reg[47:16];
    assign x1 = x0 + 32'd1;
    assign y1 = y0 + 32'd1;
    assign tx = px_reg[15:0];
    assign ty = py_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx0_reg <= x0 * fvn_pkg::HASH_MUL_X;
            hx1_reg <= x1 * fvn_pkg::HASH_MUL_X;
            hy0_reg <= y0 * fvn_pkg::HASH_MUL_Y;
            hy1_reg <= y1 * fvn_pkg::HASH_MUL_Y;
            ttx_reg <= {16'd0, tx} * {16'd0, tx};
            tty_reg <= {16'd0, ty} * {16'd0, ty};
            tx_reg  <= tx;
            ty_reg  <= ty;
        end
    end

    // stage 3: hash mixing multiply, smoothstep weights
    logic [17:0] wx;
    logic [17:0] wy;
    logic [49:0] smx;
    logic [49:0] smy;
    logic [31:0] m00_reg;
    logic [31:0] m10_reg;
    logic [31:0] m01_reg;
    logic [31:0] m11_reg;
    logic [16:0] sx_reg;
    logic [16:0] sy_reg;

    assign wx  = 18'd196608 - {1'b0, tx_reg, 1'b0};
    assign wy  = 18'd196608 - {1'b0, ty_reg, 1'b0};
    assign smx = {18'd0, ttx_reg} * {32'd0, wx};
    assign smy = {18'd0, tty_reg} * {32'd0, wy};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m00_reg <= corner_mix(seed, hx0_reg, hy0_reg);
            m10_reg <= corner_mix(seed, hx1_reg, hy0_reg);
            m01_reg <= corner_mix(seed, hx0_reg, hy1_reg);
            m11_reg <= corner_mix(seed, hx1_reg, hy1_reg);
            sx_reg  <= smx[48:32];
            sy_reg  <= smy[48:32];
        end
    end

    // stage 4: finish the hashes, blend along x
    logic [23:0] r0_reg;
    logic [23:0] r1_reg;
    logic [16:0] sy4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg  <= blend24(corner_fin(m00_reg), corner_fin(m10_reg), sx_reg);
            r1_reg  <= blend24(corner_fin(m01_reg), corner_fin(m11_reg), sx_reg);
            sy4_reg <= sy_reg;
        end
    end

    // stage 5: blend along y
    logic [23:0] v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= blend24(r0_reg, r1_reg, sy4_reg);
        end
    end

    // stage 6: map to -1..1 and weight by amplitude
    logic signed [25:0] nsig;
    logic signed [58:0] prod_reg;

    assign nsig = $signed({1'b0, v_reg, 1'b0}) - 26'sd16777216;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= nsig * $signed({1'b0, amp_reg[5]});
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 6; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= 6; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid <= vld_reg[6];
        end
    end

    // stage 7: accumulate when this octave is in use
    fvn_pkg::oct_bus_t acc_next;

    always_comb
    begin
        acc_next = pass_reg[6];
        if (act_reg[6])
        begin
            acc_next.total = pass_reg[6].total + {{5{prod_reg[58]}}, prod_reg};
            acc_next.norm  = pass_reg[6].norm + {5'd0, amp_reg[6]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_bus <= acc_next;
        end
    end

endmodule

### hdl/fvn_div_cell.sv
// ----------------------------------------------------------------------------
// fvn_div_cell
// One restoring-division step: settle one quotient bit.
// ----------------------------------------------------------------------------
module fvn_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  fvn_pkg::div_bus_t    in_bus,
    output logic                 out_valid,
    output fvn_pkg::div_bus_t    out_bus
);

    logic [63:0]       dsh;
    logic              fits;
    fvn_pkg::div_bus_t step_next;

    assign dsh  = 64'(in_bus.den) << SHIFT;
    assign fits = (in_bus.rem >= dsh);

    always_comb
    begin
        step_next = in_bus;
        if (fits)
        begin
            step_next.rem        = in_bus.rem - dsh;
            step_next.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_bus <= step_next;
        end
    end

endmodule

### hdl/fractal_value_noise.sv
// ----------------------------------------------------------------------------
// fractal_value_noise
// Fractal value noise over a 2-D lattice, one sample per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Present x_coord / y_coord (signed Q16.16) on the coord channel; a transfer
//   happens when coord_valid and coord_ready are both high. Each transfer
//   yields one noise_value (signed Q.16, -1..1) on the noise channel.
//   Each sample passes through every octave stage in the chain, the sign and
//   rounding set-up, eighteen divider steps and the output register.
//   Throughput is one sample per cycle while the receiver is not stalling;
//   every octave stage and divider step is its own pipeline slice.
//   Octaves beyond octave_count pass their sums through unchanged.
//   When the receiver stalls, the whole pipeline holds and coord_ready drops
//   until the held result is taken.
//   The user must write registers on the cfg channel (always ready) only
//   while no sample is in flight; the block does not enforce it. Reset empties
//   the pipeline and loads seed 0, four octaves, lacunarity 2.0, gain 0.5.
// ----------------------------------------------------------------------------
module fractal_value_noise #(
    parameter int unsigned MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               coord_valid,
    output logic               coord_ready,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic               noise_valid,
    input  logic               noise_ready,
    output logic signed [17:0] noise_value
);

    localparam int unsigned QW = fvn_pkg::QUO_W;

    // ---------------- configuration registers ----------------
    logic [31:0] seed_reg;
    logic [3:0]  oct_reg;
    logic [15:0] lac_reg;
    logic [15:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= fvn_pkg::SEED_RST;
            oct_reg  <= fvn_pkg::OCT_RST;
            lac_reg  <= fvn_pkg::LAC_RST;
            gain_reg <= fvn_pkg::GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fvn_pkg::reg_idx_t'(cfg_index))
                fvn_pkg::REG_SEED:    seed_reg <= cfg_data;
                fvn_pkg::REG_OCTAVES: oct_reg  <= cfg_data[3:0];
                fvn_pkg::REG_LACUN:   lac_reg  <= cfg_data[15:0];
                fvn_pkg::REG_GAIN:    gain_reg <= cfg_data[15:0];
                default:              ;
            endcase
        end
    end

    // Clamp the octave count to the number of stages built.
    logic [4:0] octs;
    assign octs = ({1'b0, oct_reg} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, oct_reg};

    // ---------------- pipeline advance ----------------
    // Advance everything while the output slot is empty or being drained.
    logic en;
    assign en          = !noise_valid || noise_ready;
    assign coord_ready = en;

    // ---------------- octave chain ----------------
    fvn_pkg::oct_bus_t oct_bus [0:MAX_OCTAVES];
    logic              oct_vld [0:MAX_OCTAVES];

    always_comb
    begin
        oct_bus[0].x     = x_coord;
        oct_bus[0].y     = y_coord;
        oct_bus[0].freq  = fvn_pkg::FREQ_ONE;
        oct_bus[0].amp   = fvn_pkg::AMP_ONE;
        oct_bus[0].total = '0;
        oct_bus[0].norm  = '0;
        oct_vld[0]       = coord_valid;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_OCTAVES; k++)
        begin : g_oct
            fvn_octave_cell #(
                .K (k)
            ) u_oct (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .active     (5'(k) < octs),
                .noise_seed (seed_reg),
                .lacunarity (lac_reg),
                .gain       (gain_reg),
                .in_valid   (oct_vld[k]),
                .in_bus     (oct_bus[k]),
                .out_valid  (oct_vld[k+1]),
                .out_bus    (oct_bus[k+1])
            );
        end
    endgenerate

    // ---------------- normalization set-up ----------------
    logic                       d0_vld_reg;
    logic                       d0_neg_reg;
    logic [63:0]                d0_mag_reg;
    logic [fvn_pkg::NORM_W-1:0] d0_norm_reg;
    logic                       d1_vld_reg;
    fvn_pkg::div_bus_t          d1_bus_reg;
    logic                       d2_vld_reg;
    fvn_pkg::div_bus_t          d2_bus_reg;
    fvn_pkg::div_bus_t          d2_bus_next;

    fvn_pkg::oct_bus_t last_bus;
    logic [63:0]       den_top;

    assign last_bus = oct_bus[MAX_OCTAVES];
    assign den_top  = 64'(d1_bus_reg.den) << QW;

    // flag quotients too large for the divider; they clamp anyway
    always_comb
    begin
        d2_bus_next     = d1_bus_reg;
        d2_bus_next.ovf = (d1_bus_reg.rem >= den_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_vld_reg <= 1'b0;
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d0_vld_reg <= oct_vld[MAX_OCTAVES];
            d1_vld_reg <= d0_vld_reg;
            d2_vld_reg <= d1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // take the magnitude of the weighted sum
            d0_neg_reg  <= last_bus.total[63];
            d0_mag_reg  <= last_bus.total[63] ? (64'd0 - last_bus.total) : last_bus.total;
            d0_norm_reg <= last_bus.norm;
            // add half the divisor to round halves away from zero
            d1_bus_reg.rem  <= d0_mag_reg + (64'(d0_norm_reg) << 7);
            d1_bus_reg.den  <= {d0_norm_reg, 8'd0};
            d1_bus_reg.quo  <= '0;
            d1_bus_reg.neg  <= d0_neg_reg;
            d1_bus_reg.zero <= (d0_norm_reg == '0);
            d1_bus_reg.ovf  <= 1'b0;
            d2_bus_reg      <= d2_bus_next;
        end
    end

    // ---------------- divider chain ----------------
    fvn_pkg::div_bus_t div_bus [0:QW];
    logic              div_vld [0:QW];

    assign div_bus[0] = d2_bus_reg;
    assign div_vld[0] = d2_vld_reg;

    genvar b;
    generate
        for (b = 0; b < QW; b++)
        begin : g_div
            fvn_div_cell #(
                .SHIFT (QW - 1 - b)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (div_vld[b]),
                .in_bus    (div_bus[b]),
                .out_valid (div_vld[b+1]),
                .out_bus   (div_bus[b+1])
            );
        end
    endgenerate

    // ---------------- output register ----------------
    fvn_pkg::div_bus_t fin;
    logic [17:0]       mag_clamp;
    logic signed [17:0] value_next;

    assign fin       = div_bus[QW];
    assign mag_clamp = (fin.ovf || (fin.quo > fvn_pkg::NOISE_FULL)) ? fvn_pkg::NOISE_FULL
                                                                     : fin.quo;

    always_comb
    begin
        if (fin.zero)
        begin
            value_next = '0;
        end
        else if (fin.neg)
        begin
            value_next = $signed(18'd0 - mag_clamp);
        end
        else
        begin
            value_next = $signed(mag_clamp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_valid <= 1'b0;
        end
        else if (en)
        begin
            noise_valid <= div_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            noise_value <= value_next;
        end
    end

`ifndef ASSERT_OFF
    // A held result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid && !noise_ready |=> noise_valid && $stable(noise_value))
        else $error("noise result dropped while stalled");

    // Results stay inside -1..1.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid |-> (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536))
        else $error("noise value out of range");

    // With no octaves configured the output is zero.
    a_zero_oct: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid && (oct_reg == 4'd0) |-> noise_value == 18'sd0)
        else $error("zero octaves gave nonzero noise");
`endif

endmodule
